### design/mekpw_pkg.sv
`default_nettype none

package mekpw_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int WIDE_W    = PROD_W + 2;
   localparam int Q_BITS    = DATA_W;
   localparam int REM_W     = PROD_W + 1;
   localparam int DIV_LAT   = Q_BITS + 2;
   localparam int NUM_PAIRS = 6;
   localparam int REG_IDX_W = 2;

   localparam int PAIR_XX = 0;
   localparam int PAIR_YY = 1;
   localparam int PAIR_ZZ = 2;
   localparam int PAIR_XY = 3;
   localparam int PAIR_XZ = 4;
   localparam int PAIR_YZ = 5;

   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(VAL_MAX);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(VAL_MIN);
   localparam logic [WIDE_W-1:0]        HALF    = WIDE_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [REG_IDX_W-1:0] {
      REG_C_ELEVEN      = 2'd0,
      REG_C_TWELVE      = 2'd1,
      REG_C_FORTYFOUR   = 2'd2,
      REG_MISFIT_STRAIN = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] v;
      logic                     ov;
   } sat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kernel_value;
      logic                     skipped;
      logic                     overflowed;
   } rsp_word_type;

   function automatic sat_type sat32(input logic signed [WIDE_W-1:0] x);
      sat_type r;
      if (x > SAT_MAX) begin
         r.v  = VAL_MAX;
         r.ov = 1'b1;
      end else if (x < SAT_MIN) begin
         r.v  = VAL_MIN;
         r.ov = 1'b1;
      end else begin
         r.v  = x[DATA_W-1:0];
         r.ov = 1'b0;
      end
      return r;
   endfunction

   function automatic sat_type rsh(input logic signed [WIDE_W-1:0] p);
      logic [WIDE_W-1:0]        m;
      logic [WIDE_W-1:0]        r;
      logic signed [WIDE_W-1:0] sv;
      m  = p[WIDE_W-1] ? WIDE_W'(-p) : WIDE_W'(p);
      r  = (m + HALF) >> FRAC_BITS;
      sv = p[WIDE_W-1] ? -$signed(r) : $signed(r);
      return sat32(sv);
   endfunction

   function automatic logic signed [WIDE_W-1:0] wext(input logic signed [PROD_W-1:0] x);
      return WIDE_W'(x);
   endfunction

   function automatic logic signed [WIDE_W-1:0] vext(input logic signed [DATA_W-1:0] x);
      return WIDE_W'(x);
   endfunction

   function automatic logic signed [PROD_W-1:0] mul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

endpackage

`default_nettype wire

### design/mekpw_req_if.sv
`default_nettype none

interface mekpw_req_if
   import mekpw_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] gx;
   logic signed [DATA_W-1:0] gy;
   logic signed [DATA_W-1:0] gz;
   logic [DATA_W-1:0]        g_mod_sq;
   logic                     is_origin;

   modport source(output valid, gx, gy, gz, g_mod_sq, is_origin, input ready);
   modport sink(input valid, gx, gy, gz, g_mod_sq, is_origin, output ready);
endinterface

`default_nettype wire

### design/mekpw_rsp_if.sv
`default_nettype none

interface mekpw_rsp_if
   import mekpw_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] kernel_value;
   logic                     skipped;
   logic                     overflowed;

   modport source(output valid, kernel_value, skipped, overflowed, input ready);
   modport sink(input valid, kernel_value, skipped, overflowed, output ready);
endinterface

`default_nettype wire

### design/misfit_elastic_kernel_per_wavevector_top.sv
// Elastic interaction kernel of a dilatational misfit defect in a cubic crystal.
// Each word on req_chan carries one wavevector (gx, gy, gz), its squared modulus
// and an origin mark; each produces exactly one word on rsp_chan with the kernel
// value and the skipped and overflowed flags, in order of arrival.
// The constants C11, C12, C44 and the misfit strain are written on the csr_ port,
// one register per write enable; the user must write them only while no word
// is in flight, which the block itself does not enforce. A word passes
// stage 1, two ranks of pipelined restoring dividers of Q_BITS+2 stages each,
// the multiply and rounding stages around them and the output register.
// Every stage advances together, one word per cycle while the skid is empty.
// A skid register behind the output register lets one more word leave the
// pipeline while rsp_chan is stalled; req_chan.ready falls only while that skid
// register is full, and nothing in the pipeline is lost or repeated.
// Synchronous reset empties the pipeline and clears the four constants to zero.
`default_nettype none

module misfit_elastic_kernel_per_wavevector_top
   import mekpw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   mekpw_req_if.sink                req_chan,
   mekpw_rsp_if.source              rsp_chan,
   input  wire logic                csr_write_enable,
   input  wire reg_index_type       csr_index,
   input  wire logic [DATA_W-1:0]   csr_write_data
);

   typedef logic signed [DATA_W-1:0] val_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // Configuration registers and the constants derived from them.
   val_type  c11_ff, c12_ff, c44_ff, e_ff;
   val_type  k_ff, dg_ff, od_ff, s_ff, se_ff, ss_ff, cst_ff;
   prod_type kprod_ff, seprod_ff, ssprod_ff;
   logic     ov1_ff, ov3_ff, ov5_ff, ov6_ff;
   logic     cfg_ov;
   sat_type  k_in, dg_in, od_in, s_in, se_in, ss_in, cst_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         c11_ff <= '0;
         c12_ff <= '0;
         c44_ff <= '0;
         e_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_C_ELEVEN:      c11_ff <= csr_write_data;
            REG_C_TWELVE:      c12_ff <= csr_write_data;
            REG_C_FORTYFOUR:   c44_ff <= csr_write_data;
            REG_MISFIT_STRAIN: e_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      k_in   = sat32(vext(c11_ff) + vext(c12_ff) + vext(c12_ff));
      dg_in  = sat32(vext(c11_ff) - vext(c44_ff));
      od_in  = sat32(vext(c12_ff) + vext(c44_ff));
      s_in   = rsh(wext(kprod_ff));
      se_in  = rsh(wext(seprod_ff));
      ss_in  = rsh(wext(ssprod_ff));
      cst_in = sat32(vext(se_ff) + vext(se_ff) + vext(se_ff));
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in.v;
      dg_ff     <= dg_in.v;
      od_ff     <= od_in.v;
      ov1_ff    <= k_in.ov | dg_in.ov | od_in.ov;
      kprod_ff  <= mul(k_ff, e_ff);
      s_ff      <= s_in.v;
      ov3_ff    <= s_in.ov;
      seprod_ff <= mul(s_ff, e_ff);
      ssprod_ff <= mul(s_ff, s_ff);
      se_ff     <= se_in.v;
      ss_ff     <= ss_in.v;
      ov5_ff    <= se_in.ov | ss_in.ov;
      cst_ff    <= cst_in.v;
      ov6_ff    <= cst_in.ov;
   end

   assign cfg_ov = ov1_ff | ov3_ff | ov5_ff | ov6_ff;

   // Pipeline control.
   logic pipe_en;
   logic skid_vld_ff;
   logic out_vld_ff;

   assign pipe_en        = !skid_vld_ff;
   assign req_chan.ready = pipe_en;

   // Stage 1: wavevector products.
   logic              s1_vld_ff, s1_skip_ff;
   prod_type          s1_p_ff [NUM_PAIRS];
   logic [DATA_W-1:0] s1_g2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_skip_ff         <= req_chan.is_origin || (req_chan.g_mod_sq == '0);
         s1_g2_ff           <= req_chan.g_mod_sq;
         s1_p_ff[PAIR_XX]   <= mul(req_chan.gx, req_chan.gx);
         s1_p_ff[PAIR_YY]   <= mul(req_chan.gy, req_chan.gy);
         s1_p_ff[PAIR_ZZ]   <= mul(req_chan.gz, req_chan.gz);
         s1_p_ff[PAIR_XY]   <= mul(req_chan.gx, req_chan.gy);
         s1_p_ff[PAIR_XZ]   <= mul(req_chan.gx, req_chan.gz);
         s1_p_ff[PAIR_YZ]   <= mul(req_chan.gy, req_chan.gz);
      end
   end

   // Direction ratios n = g_i*g_j / |g|^2.
   sat_type n_q [NUM_PAIRS];

   for (genvar i = 0; i < NUM_PAIRS; i++) begin : g_ndiv
      logic [PROD_W-1:0] mag;
      always_comb begin
         mag = s1_p_ff[i][PROD_W-1] ? PROD_W'(-s1_p_ff[i]) : PROD_W'(s1_p_ff[i]);
      end
      mekpw_div u_div (
         .clock (clock),
         .en    (pipe_en),
         .num   (mag),
         .den   (s1_g2_ff),
         .neg   (s1_p_ff[i][PROD_W-1]),
         .quo   (n_q[i])
      );
   end

   logic d1_vld_ff  [DIV_LAT];
   logic d1_skip_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            d1_vld_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         d1_vld_ff[0] <= s1_vld_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            d1_vld_ff[i] <= d1_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d1_skip_ff[0] <= s1_skip_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            d1_skip_ff[i] <= d1_skip_ff[i-1];
         end
      end
   end

   // Stage 3: acoustic tensor products.
   logic     s3_vld_ff, s3_skip_ff, s3_ov_ff;
   prod_type s3_m_ff [NUM_PAIRS];
   val_type  s3_n_ff [NUM_PAIRS];
   logic     s3_ov_in;

   always_comb begin
      s3_ov_in = 1'b0;
      for (int i = 0; i < NUM_PAIRS; i++) begin
         s3_ov_in = s3_ov_in | n_q[i].ov;
      end
   end

   // Stage 4: acoustic tensor.
   logic    s4_vld_ff, s4_skip_ff, s4_ov_ff;
   val_type s4_a_ff [NUM_PAIRS];
   val_type s4_n_ff [NUM_PAIRS];
   val_type s4_a_in [NUM_PAIRS];
   logic    s4_ov_in;

   always_comb begin
      sat_type t;
      sat_type r;
      s4_ov_in = s3_ov_ff;
      for (int i = 0; i < NUM_PAIRS; i++) begin
         t = rsh(wext(s3_m_ff[i]));
         if (i < 3) begin
            r = sat32(vext(c44_ff) + vext(t.v));
         end else begin
            r = t;
         end
         s4_a_in[i] = r.v;
         s4_ov_in   = s4_ov_in | t.ov | r.ov;
      end
   end

   // Stage 5: cofactor products; stage 6: adjugate.
   logic     s5_vld_ff, s5_skip_ff, s5_ov_ff;
   prod_type s5_pa_ff [NUM_PAIRS];
   prod_type s5_pb_ff [NUM_PAIRS];
   val_type  s5_a_ff  [NUM_PAIRS];
   val_type  s5_n_ff  [NUM_PAIRS];

   logic    s6_vld_ff, s6_skip_ff, s6_ov_ff;
   val_type s6_adj_ff [NUM_PAIRS];
   val_type s6_a_ff   [NUM_PAIRS];
   val_type s6_n_ff   [NUM_PAIRS];
   val_type s6_adj_in [NUM_PAIRS];
   logic    s6_ov_in;

   always_comb begin
      sat_type t;
      s6_ov_in = s5_ov_ff;
      for (int i = 0; i < NUM_PAIRS; i++) begin
         t            = rsh(wext(s5_pa_ff[i]) - wext(s5_pb_ff[i]));
         s6_adj_in[i] = t.v;
         s6_ov_in     = s6_ov_in | t.ov;
      end
   end

   // Stage 7: determinant and numerator products; stage 8: rounding.
   logic     s7_vld_ff, s7_skip_ff, s7_ov_ff;
   prod_type s7_dp_ff [3];
   prod_type s7_up_ff [NUM_PAIRS];

   logic    s8_vld_ff, s8_skip_ff, s8_ov_ff;
   val_type s8_dr_ff [3];
   val_type s8_ur_ff [NUM_PAIRS];
   val_type s8_dr_in [3];
   val_type s8_ur_in [NUM_PAIRS];
   logic    s8_ov_in;

   always_comb begin
      sat_type t;
      s8_ov_in = s7_ov_ff;
      for (int i = 0; i < 3; i++) begin
         t           = rsh(wext(s7_dp_ff[i]));
         s8_dr_in[i] = t.v;
         s8_ov_in    = s8_ov_in | t.ov;
      end
      for (int i = 0; i < NUM_PAIRS; i++) begin
         t           = rsh(wext(s7_up_ff[i]));
         s8_ur_in[i] = t.v;
         s8_ov_in    = s8_ov_in | t.ov;
      end
   end

   // Stage 9: determinant and numerator sums.
   logic    s9_vld_ff, s9_skip_ff, s9_ov_ff;
   val_type s9_det_ff, s9_u_ff;
   sat_type det_in, u_in;

   always_comb begin
      logic signed [WIDE_W-1:0] off;
      off    = vext(s8_ur_ff[PAIR_XY]) + vext(s8_ur_ff[PAIR_XZ]) + vext(s8_ur_ff[PAIR_YZ]);
      det_in = sat32(vext(s8_dr_ff[0]) + vext(s8_dr_ff[1]) + vext(s8_dr_ff[2]));
      u_in   = sat32(vext(s8_ur_ff[PAIR_XX]) + vext(s8_ur_ff[PAIR_YY])
                     + vext(s8_ur_ff[PAIR_ZZ]) + off + off);
   end

   // Quotient u / det.
   sat_type           q_q;
   logic [DATA_W-1:0] u_mag, det_mag;

   always_comb begin
      u_mag   = s9_u_ff[DATA_W-1] ? DATA_W'(-s9_u_ff) : DATA_W'(s9_u_ff);
      det_mag = s9_det_ff[DATA_W-1] ? DATA_W'(-s9_det_ff) : DATA_W'(s9_det_ff);
   end

   mekpw_div u_qdiv (
      .clock (clock),
      .en    (pipe_en),
      .num   (PROD_W'(u_mag) << FRAC_BITS),
      .den   (det_mag),
      .neg   (s9_u_ff[DATA_W-1] ^ s9_det_ff[DATA_W-1]),
      .quo   (q_q)
   );

   logic d2_vld_ff  [DIV_LAT];
   logic d2_skip_ff [DIV_LAT];
   logic d2_ov_ff   [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            d2_vld_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         d2_vld_ff[0] <= s9_vld_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            d2_vld_ff[i] <= d2_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d2_skip_ff[0] <= s9_skip_ff;
         d2_ov_ff[0]   <= s9_ov_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            d2_skip_ff[i] <= d2_skip_ff[i-1];
            d2_ov_ff[i]   <= d2_ov_ff[i-1];
         end
      end
   end

   // Stage 10: scale product; stage 11: final kernel word.
   logic         s10_vld_ff, s10_skip_ff, s10_ov_ff;
   prod_type     s10_prod_ff;
   logic         pl_vld_ff;
   rsp_word_type pl_word_ff;
   rsp_word_type pl_word_in;

   always_comb begin
      sat_type t;
      sat_type r;
      t = rsh(wext(s10_prod_ff));
      r = sat32(vext(cst_ff) - vext(t.v));
      if (s10_skip_ff) begin
         pl_word_in.kernel_value = '0;
         pl_word_in.skipped      = 1'b1;
         pl_word_in.overflowed   = 1'b0;
      end else begin
         pl_word_in.kernel_value = r.v;
         pl_word_in.skipped      = 1'b0;
         pl_word_in.overflowed   = s10_ov_ff | t.ov | r.ov | cfg_ov;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s7_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
         pl_vld_ff  <= 1'b0;
      end else if (pipe_en) begin
         s3_vld_ff  <= d1_vld_ff[DIV_LAT-1];
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         s7_vld_ff  <= s6_vld_ff;
         s8_vld_ff  <= s7_vld_ff;
         s9_vld_ff  <= s8_vld_ff;
         s10_vld_ff <= d2_vld_ff[DIV_LAT-1];
         pl_vld_ff  <= s10_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_skip_ff <= d1_skip_ff[DIV_LAT-1];
         s3_ov_ff   <= s3_ov_in;
         for (int i = 0; i < NUM_PAIRS; i++) begin
            s3_n_ff[i] <= n_q[i].v;
            s3_m_ff[i] <= mul((i < 3) ? dg_ff : od_ff, n_q[i].v);
         end

         s4_skip_ff <= s3_skip_ff;
         s4_ov_ff   <= s4_ov_in;
         s4_a_ff    <= s4_a_in;
         s4_n_ff    <= s3_n_ff;

         s5_skip_ff <= s4_skip_ff;
         s5_ov_ff   <= s4_ov_ff;
         s5_a_ff    <= s4_a_ff;
         s5_n_ff    <= s4_n_ff;
         s5_pa_ff[PAIR_XX] <= mul(s4_a_ff[PAIR_YY], s4_a_ff[PAIR_ZZ]);
         s5_pb_ff[PAIR_XX] <= mul(s4_a_ff[PAIR_YZ], s4_a_ff[PAIR_YZ]);
         s5_pa_ff[PAIR_YY] <= mul(s4_a_ff[PAIR_XX], s4_a_ff[PAIR_ZZ]);
         s5_pb_ff[PAIR_YY] <= mul(s4_a_ff[PAIR_XZ], s4_a_ff[PAIR_XZ]);
         s5_pa_ff[PAIR_ZZ] <= mul(s4_a_ff[PAIR_XX], s4_a_ff[PAIR_YY]);
         s5_pb_ff[PAIR_ZZ] <= mul(s4_a_ff[PAIR_XY], s4_a_ff[PAIR_XY]);
         s5_pa_ff[PAIR_XY] <= mul(s4_a_ff[PAIR_XZ], s4_a_ff[PAIR_YZ]);
         s5_pb_ff[PAIR_XY] <= mul(s4_a_ff[PAIR_XY], s4_a_ff[PAIR_ZZ]);
         s5_pa_ff[PAIR_XZ] <= mul(s4_a_ff[PAIR_XY], s4_a_ff[PAIR_YZ]);
         s5_pb_ff[PAIR_XZ] <= mul(s4_a_ff[PAIR_XZ], s4_a_ff[PAIR_YY]);
         s5_pa_ff[PAIR_YZ] <= mul(s4_a_ff[PAIR_XY], s4_a_ff[PAIR_XZ]);
         s5_pb_ff[PAIR_YZ] <= mul(s4_a_ff[PAIR_XX], s4_a_ff[PAIR_YZ]);

         s6_skip_ff <= s5_skip_ff;
         s6_ov_ff   <= s6_ov_in;
         s6_adj_ff  <= s6_adj_in;
         s6_a_ff    <= s5_a_ff;
         s6_n_ff    <= s5_n_ff;

         s7_skip_ff  <= s6_skip_ff;
         s7_ov_ff    <= s6_ov_ff;
         s7_dp_ff[0] <= mul(s6_a_ff[PAIR_XX], s6_adj_ff[PAIR_XX]);
         s7_dp_ff[1] <= mul(s6_a_ff[PAIR_XY], s6_adj_ff[PAIR_XY]);
         s7_dp_ff[2] <= mul(s6_a_ff[PAIR_XZ], s6_adj_ff[PAIR_XZ]);
         for (int i = 0; i < NUM_PAIRS; i++) begin
            s7_up_ff[i] <= mul(s6_adj_ff[i], s6_n_ff[i]);
         end

         s8_skip_ff <= s7_skip_ff;
         s8_ov_ff   <= s8_ov_in;
         s8_dr_ff   <= s8_dr_in;
         s8_ur_ff   <= s8_ur_in;

         s9_skip_ff <= s8_skip_ff || (det_in.v == '0);
         s9_ov_ff   <= s8_ov_ff | det_in.ov | u_in.ov;
         s9_det_ff  <= det_in.v;
         s9_u_ff    <= u_in.v;

         s10_skip_ff <= d2_skip_ff[DIV_LAT-1];
         s10_ov_ff   <= d2_ov_ff[DIV_LAT-1] | q_q.ov;
         s10_prod_ff <= mul(ss_ff, q_q.v);

         pl_word_ff <= pl_word_in;
      end
   end

   // Output register with one skid word behind it.
   rsp_word_type out_word_ff;
   rsp_word_type skid_word_ff;
   logic         pop;
   logic         out_take;

   assign pop      = pipe_en && pl_vld_ff;
   assign out_take = !out_vld_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= pop;
         end
      end else if (pop) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_word_ff <= skid_vld_ff ? skid_word_ff : pl_word_ff;
      end else if (pop) begin
         skid_word_ff <= pl_word_ff;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.kernel_value = out_word_ff.kernel_value;
   assign rsp_chan.skipped      = out_word_ff.skipped;
   assign rsp_chan.overflowed   = out_word_ff.overflowed;

   a_skip_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.skipped |->
         rsp_chan.kernel_value == '0 && !rsp_chan.overflowed)
      else $error("skipped word carries a value or an overflow flag");

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word held while the output register is empty");

   a_stall_fills_skid : assert property (@(posedge clock) disable iff (reset)
      pop && out_vld_ff && !rsp_chan.ready |=> skid_vld_ff)
      else $error("word left the pipeline during a stall but was not kept");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && rsp_chan.ready |=> out_vld_ff && !skid_vld_ff)
      else $error("skid word not moved to the output register");

endmodule

`default_nettype wire

### design/mekpw_div.sv
`default_nettype none

module mekpw_div
   import mekpw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic [PROD_W-1:0]   num,
   input  wire logic [DATA_W-1:0]   den,
   input  wire logic                neg,
   output sat_type                  quo
);

   logic [REM_W-1:0]  rem_ff [0:Q_BITS];
   logic [Q_BITS-1:0] q_ff   [0:Q_BITS];
   logic [DATA_W-1:0] den_ff [0:Q_BITS];
   logic              neg_ff [0:Q_BITS];
   logic              big_ff [0:Q_BITS];
   sat_type           out_ff;
   sat_type           out_in;
   logic [REM_W-1:0]  start;

   always_comb begin
      start = REM_W'(num) + REM_W'(den >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= start;
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         big_ff[0] <= start >= (REM_W'(den) << Q_BITS);
      end
   end

   for (genvar j = 1; j <= Q_BITS; j++) begin : g_step
      localparam int B = Q_BITS - j;
      logic [REM_W-1:0] sub;
      logic             ge;

      always_comb begin
         sub = REM_W'(den_ff[j-1]) << B;
         ge  = rem_ff[j-1] >= sub;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? rem_ff[j-1] - sub : rem_ff[j-1];
            q_ff[j]   <= q_ff[j-1] | (ge ? (Q_BITS'(1) << B) : Q_BITS'(0));
            den_ff[j] <= den_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            big_ff[j] <= big_ff[j-1];
         end
      end
   end

   always_comb begin
      logic [Q_BITS-1:0] q;
      logic              over;
      q    = q_ff[Q_BITS];
      over = big_ff[Q_BITS] ||
             (neg_ff[Q_BITS] ? (q > Q_BITS'(VAL_MIN)) : q[Q_BITS-1]);
      if (over) begin
         out_in.v  = neg_ff[Q_BITS] ? VAL_MIN : VAL_MAX;
         out_in.ov = 1'b1;
      end else begin
         out_in.v  = neg_ff[Q_BITS] ? -$signed(q) : $signed(q);
         out_in.ov = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign quo = out_ff;

endmodule

`default_nettype wire
